// File: rtl/fcs_pkg.sv
package fcs_pkg;

    // Default sizes of the angle and position words.
    localparam int ANGLE_BITS_DEF = 16;
    localparam int POS_BITS_DEF   = 32;

    // Configuration port sizes and register indexes.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_GAIN = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION_GAIN = 8'd3;

    // Register reset values.
    localparam logic signed [23:0] OFFSET_X_RST      = 24'sd0;
    localparam logic signed [23:0] OFFSET_Y_RST      = -24'sd64000;
    localparam logic [15:0]        POSITION_GAIN_RST = 16'd2048;
    localparam logic [15:0]        ROTATION_GAIN_RST = 16'd2560;

    // Quarter-wave sine polynomial coefficients, Q16.
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42047;
    localparam logic [16:0] SIN_C = 17'd4640;
    localparam logic [15:0] SIN_MAX = 16'd32767;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GROT,
        ST_DANG,
        ST_ANG,
        ST_GPOS,
        ST_SX2,
        ST_ST1,
        ST_ST2,
        ST_SY,
        ST_O0,
        ST_O1,
        ST_O2,
        ST_O3,
        ST_O4,
        ST_P1,
        ST_P2
    } fcs_state_t;

endpackage

// File: rtl/follow_camera_smoother_top.sv
// Smoothed follow camera. Each input beat (time step, target heading, target
// position) turns the kept camera angle toward the heading along the shortest
// wrapped difference, rotates the configured look-ahead offset by the sine and
// cosine of the new angle, and moves the kept camera position toward target
// plus offset; one output beat with the new position and angle follows. Every
// product goes through a single shared signed multiplier, seventeen products
// in a row under a small sequencer, and in_stall stays high while the item is
// at work. The sequencer returns to idle between items, so a new item is
// accepted only after the last one has left the sequencer. A finished beat
// waits in the output register, so the
// next item may be accepted while it is still stalled; if it is still waiting
// when the next item finishes, the sequencer holds in its last step until the
// output register frees. Configuration writes are always ready.
module follow_camera_smoother_top #(
    parameter int ANGLE_BITS = fcs_pkg::ANGLE_BITS_DEF,
    parameter int POS_BITS   = fcs_pkg::POS_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [15:0]                        time_step,
    input  logic [ANGLE_BITS-1:0]              target_angle,
    input  logic signed [POS_BITS-1:0]         target_x,
    input  logic signed [POS_BITS-1:0]         target_y,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [POS_BITS-1:0]         camera_x,
    output logic signed [POS_BITS-1:0]         camera_y,
    output logic [ANGLE_BITS-1:0]              camera_angle,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fcs_pkg::*;

    // Rotated offset width and position difference width.
    localparam int OW = 27;
    localparam int DW = ((POS_BITS > OW) ? POS_BITS : OW) + 2;
    localparam int AW = DW;
    localparam int BW = 33;
    localparam int PW = AW + BW;

    fcs_state_t state_reg, state_next;

    logic signed [23:0]          off_x_reg, off_y_reg;
    logic [15:0]                 pos_gain_reg, rot_gain_reg;
    logic [ANGLE_BITS-1:0]       cam_angle_reg;
    logic signed [POS_BITS-1:0]  cam_x_reg, cam_y_reg;

    logic [15:0]                 dt_reg;
    logic [ANGLE_BITS-1:0]       tang_reg;
    logic signed [POS_BITS-1:0]  tx_reg, ty_reg;

    logic signed [PW-1:0]        prod_reg, acc_reg;
    logic [31:0]                 gpos_reg;
    logic [16:0]                 x_reg, x2_reg;
    logic [1:0]                  quad_reg;
    logic                        cos_sel_reg;
    logic signed [15:0]          sin_reg, cos_reg;
    logic signed [OW-1:0]        offx_reg, offy_reg;

    logic                        out_valid_reg;
    logic signed [POS_BITS-1:0]  out_x_reg, out_y_reg;
    logic [ANGLE_BITS-1:0]       out_angle_reg;

    logic signed [AW-1:0]        mul_a;
    logic signed [BW-1:0]        mul_b;
    logic signed [PW-1:0]        ext_a, ext_b;

    logic                        in_accept, cfg_accept, out_free;
    logic signed [ANGLE_BITS-1:0] diff;
    logic [31:0]                 phase;
    logic [16:0]                 x_start, prod_hi16;
    logic [16:0]                 y_raw;
    logic [15:0]                 y_cap;
    logic signed [15:0]          sine_val;
    logic signed [PW-1:0]        rnd24, rnd15_sub, rnd15_add;
    logic signed [DW-1:0]        dx, dy;

    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);

    assign out_valid    = out_valid_reg;
    assign camera_x     = out_x_reg;
    assign camera_y     = out_y_reg;
    assign camera_angle = out_angle_reg;

    // Wrapped angle difference and sine phase for the next evaluation.
    assign diff  = $signed(tang_reg - cam_angle_reg);
    assign phase = {cam_angle_reg, {(32-ANGLE_BITS){1'b0}}}
                   + ((state_reg == ST_SY) ? 32'h4000_0000 : 32'h0);
    assign x_start = phase[30] ? (17'h10000 - {1'b0, phase[29:14]})
                               : {1'b0, phase[29:14]};
    assign prod_hi16 = prod_reg[16 +: 17];

    // Polynomial result, capped and signed by quadrant.
    assign y_raw    = prod_reg[17 +: 17];
    assign y_cap    = (y_raw > {1'b0, SIN_MAX}) ? SIN_MAX : y_raw[15:0];
    assign sine_val = quad_reg[1] ? -$signed(y_cap) : $signed(y_cap);

    // Rounding of products before the final shifts.
    assign rnd24     = prod_reg + (PW'(1) <<< 23);
    assign rnd15_sub = acc_reg - prod_reg + (PW'(1) <<< 14);
    assign rnd15_add = acc_reg + prod_reg + (PW'(1) <<< 14);

    // Distances from the kept camera position to the look-ahead point.
    assign dx = DW'(tx_reg) + DW'(offx_reg) - DW'(cam_x_reg);
    assign dy = DW'(ty_reg) + DW'(offy_reg) - DW'(cam_y_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_GROT;
            ST_GROT: state_next = ST_DANG;
            ST_DANG: state_next = ST_ANG;
            ST_ANG:  state_next = ST_GPOS;
            ST_GPOS: state_next = ST_SX2;
            ST_SX2:  state_next = ST_ST1;
            ST_ST1:  state_next = ST_ST2;
            ST_ST2:  state_next = ST_SY;
            ST_SY:   state_next = cos_sel_reg ? ST_O0 : ST_SX2;
            ST_O0:   state_next = ST_O1;
            ST_O1:   state_next = ST_O2;
            ST_O2:   state_next = ST_O3;
            ST_O3:   state_next = ST_O4;
            ST_O4:   state_next = ST_P1;
            ST_P1:   state_next = ST_P2;
            ST_P2:   if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_GROT:
            begin
                mul_a = AW'($signed({1'b0, rot_gain_reg}));
                mul_b = BW'($signed({1'b0, dt_reg}));
            end
            ST_DANG:
            begin
                mul_a = AW'(diff);
                mul_b = $signed({1'b0, prod_reg[31:0]});
            end
            ST_ANG:
            begin
                mul_a = AW'($signed({1'b0, pos_gain_reg}));
                mul_b = BW'($signed({1'b0, dt_reg}));
            end
            ST_GPOS, ST_SY:
            begin
                mul_a = AW'($signed({1'b0, x_start}));
                mul_b = BW'($signed({1'b0, x_start}));
            end
            ST_SX2:
            begin
                mul_a = AW'($signed({1'b0, SIN_C}));
                mul_b = BW'($signed({1'b0, prod_hi16}));
            end
            ST_ST1:
            begin
                mul_a = AW'($signed({1'b0, SIN_B - prod_hi16}));
                mul_b = BW'($signed({1'b0, x2_reg}));
            end
            ST_ST2:
            begin
                mul_a = AW'($signed({1'b0, SIN_A - prod_hi16}));
                mul_b = BW'($signed({1'b0, x_reg}));
            end
            ST_O0:
            begin
                mul_a = AW'(off_x_reg);
                mul_b = BW'(cos_reg);
            end
            ST_O1:
            begin
                mul_a = AW'(off_y_reg);
                mul_b = BW'(sin_reg);
            end
            ST_O2:
            begin
                mul_a = AW'(off_x_reg);
                mul_b = BW'(sin_reg);
            end
            ST_O3:
            begin
                mul_a = AW'(off_y_reg);
                mul_b = BW'(cos_reg);
            end
            ST_O4:
            begin
                mul_a = AW'(dx);
                mul_b = $signed({1'b0, gpos_reg});
            end
            ST_P1:
            begin
                mul_a = AW'(dy);
                mul_b = $signed({1'b0, gpos_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign ext_a = PW'(mul_a);
    assign ext_b = PW'(mul_b);

    // Control state and kept camera state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cam_angle_reg <= '0;
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            off_x_reg     <= OFFSET_X_RST;
            off_y_reg     <= OFFSET_Y_RST;
            pos_gain_reg  <= POSITION_GAIN_RST;
            rot_gain_reg  <= ROTATION_GAIN_RST;
            out_valid_reg <= 1'b0;
            cos_sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration register writes.
            if (cfg_accept)
            begin
                case (cfg_index)
                    CFG_OFFSET_X:      off_x_reg    <= $signed(cfg_data);
                    CFG_OFFSET_Y:      off_y_reg    <= $signed(cfg_data);
                    CFG_POSITION_GAIN: pos_gain_reg <= cfg_data[15:0];
                    CFG_ROTATION_GAIN: rot_gain_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // Output beat handshake.
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_P2 && out_free)
                out_valid_reg <= 1'b1;

            if (state_reg == ST_ANG)
                cam_angle_reg <= cam_angle_reg + rnd24[24 +: ANGLE_BITS];
            if (state_reg == ST_GPOS)
                cos_sel_reg <= 1'b0;
            if (state_reg == ST_SY)
                cos_sel_reg <= 1'b1;
            if (state_reg == ST_P1)
                cam_x_reg <= cam_x_reg + $signed(rnd24[24 +: POS_BITS]);
            if (state_reg == ST_P2 && out_free)
                cam_y_reg <= cam_y_reg + $signed(rnd24[24 +: POS_BITS]);
        end
    end

    // Datapath registers. The last product is held while the last step waits.
    always_ff @(posedge clk)
    begin
        if (state_reg != ST_P2 || out_free)
            prod_reg <= ext_a * ext_b;
        if (in_accept)
        begin
            dt_reg   <= time_step;
            tang_reg <= target_angle;
            tx_reg   <= target_x;
            ty_reg   <= target_y;
        end
        case (state_reg)
            ST_GPOS:
            begin
                gpos_reg <= prod_reg[31:0];
                x_reg    <= x_start;
                quad_reg <= phase[31:30];
            end
            ST_SX2:
                x2_reg <= prod_hi16;
            ST_SY:
            begin
                if (cos_sel_reg)
                    cos_reg <= sine_val;
                else
                begin
                    sin_reg  <= sine_val;
                    x_reg    <= x_start;
                    quad_reg <= phase[31:30];
                end
            end
            ST_O1, ST_O3:
                acc_reg <= prod_reg;
            ST_O2:
                offx_reg <= rnd15_sub[15 +: OW];
            ST_O4:
                offy_reg <= rnd15_add[15 +: OW];
            ST_P2:
            begin
                if (out_free)
                begin
                    out_x_reg     <= cam_x_reg;
                    out_y_reg     <= cam_y_reg + $signed(rnd24[24 +: POS_BITS]);
                    out_angle_reg <= cam_angle_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // The camera angle moves only in its update step.
    a_angle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ANG) |=> $stable(cam_angle_reg))
        else $error("camera angle changed outside its update step");

    // An accepted item always leads to the first multiply step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_GROT))
        else $error("accepted beat did not start the sequencer");

    // Leaving the last step always loads a valid output beat.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P2 && out_free) |=> out_valid_reg)
        else $error("finished item produced no output beat");
`endif

endmodule

// File: sim/follow_camera_smoother_top_test.sv
module follow_camera_smoother_top_test;
    import fcs_pkg::*;

    typedef struct {
        logic [15:0]        dt;
        logic [15:0]        heading;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } tick_t;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [15:0]        angle;
    } camera_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        time_step = '0;
    logic [15:0]        target_angle = '0;
    logic signed [31:0] target_x = '0;
    logic signed [31:0] target_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic [15:0]        camera_angle;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    follow_camera_smoother_top DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tick_t   tick_queue[$];
    camera_t camera_expect[$];
    int      fail_count = 0;

    // Shadow copy of the registers and of the kept camera state.
    longint  sh_off_x = longint'(OFFSET_X_RST);
    longint  sh_off_y = longint'(OFFSET_Y_RST);
    longint  sh_pos_gain = longint'(POSITION_GAIN_RST);
    longint  sh_rot_gain = longint'(ROTATION_GAIN_RST);
    logic [15:0]        kept_angle = '0;
    logic signed [31:0] kept_x = '0;
    logic signed [31:0] kept_y = '0;

    // Quarter-wave polynomial sine in Q1.15 for a 32-bit phase.
    function automatic longint sine_q15(logic [31:0] ph);
        longint x, x2, t, y;
        x = longint'(ph[29:14]);
        if (ph[30])
            x = 65536 - x;
        x2 = (x * x) >> 16;
        t = (longint'(SIN_C) * x2) >> 16;
        t = longint'(SIN_B) - t;
        t = (t * x2) >> 16;
        t = longint'(SIN_A) - t;
        y = ((t * x) >> 16) >> 1;
        if (y > longint'(SIN_MAX))
            y = longint'(SIN_MAX);
        return ph[31] ? -y : y;
    endfunction

    // round(d * g / 2^24) split so the product cannot overflow.
    function automatic longint scaled_move(longint d, longint g);
        longint hi, lo;
        hi = d >>> 24;
        lo = d - (hi <<< 24);
        return hi * g + ((lo * g + (64'sd1 <<< 23)) >> 24);
    endfunction

    // Advance the kept camera by one tick and return the new camera.
    function automatic camera_t follow_tick(tick_t tk);
        camera_t            res;
        logic signed [15:0] diff;
        logic [15:0]        dang;
        longint             s, c, offx, offy, g, mv;
        diff = tk.heading - kept_angle;
        mv = (longint'(diff) * (sh_rot_gain * longint'(tk.dt)) + (64'sd1 <<< 23)) >>> 24;
        dang = mv[15:0];
        kept_angle = kept_angle + dang;
        s = sine_q15({kept_angle, 16'h0000});
        c = sine_q15({kept_angle, 16'h0000} + 32'h4000_0000);
        offx = (sh_off_x * c - sh_off_y * s + (64'sd1 <<< 14)) >>> 15;
        offy = (sh_off_x * s + sh_off_y * c + (64'sd1 <<< 14)) >>> 15;
        g = sh_pos_gain * longint'(tk.dt);
        mv = longint'(kept_x) + scaled_move(longint'(tk.px) + offx - longint'(kept_x), g);
        kept_x = mv[31:0];
        mv = longint'(kept_y) + scaled_move(longint'(tk.py) + offy - longint'(kept_y), g);
        kept_y = mv[31:0];
        res.cx = kept_x;
        res.cy = kept_y;
        res.angle = kept_angle;
        return res;
    endfunction

    // Register shadow follows accepted configuration beats.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OFFSET_X:      sh_off_x = longint'($signed(cfg_data));
                CFG_OFFSET_Y:      sh_off_y = longint'($signed(cfg_data));
                CFG_POSITION_GAIN: sh_pos_gain = longint'(cfg_data[15:0]);
                CFG_ROTATION_GAIN: sh_rot_gain = longint'(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // Driver: bursts of beats with random gaps, payload held while stalled.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        tick_t tk;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                tk.dt = time_step;
                tk.heading = target_angle;
                tk.px = target_x;
                tk.py = target_y;
                camera_expect.push_back(follow_tick(tk));
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() > 0)
                begin
                    tk = tick_queue.pop_front();
                    time_step <= tk.dt;
                    target_angle <= tk.heading;
                    target_x <= tk.px;
                    target_y <= tk.py;
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output beat and stalls on its own pattern.
    int stall_mode = 0;
    int stall_timer = 0;
    always @(posedge clk)
    begin
        camera_t ex;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (camera_expect.size() == 0)
                begin
                    $error("output beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    ex = camera_expect.pop_front();
                    if (camera_x !== ex.cx)
                    begin
                        $error("camera_x expected %0d got %0d", ex.cx, camera_x);
                        fail_count++;
                    end
                    if (camera_y !== ex.cy)
                    begin
                        $error("camera_y expected %0d got %0d", ex.cy, camera_y);
                        fail_count++;
                    end
                    if (camera_angle !== ex.angle)
                    begin
                        $error("camera_angle expected %0d got %0d", ex.angle, camera_angle);
                        fail_count++;
                    end
                end
            end
            if (stall_timer == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_timer = $urandom_range(50, 400);
            end
            else
                stall_timer--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every queued tick is in and every camera beat is out.
    task automatic drain();
        @(posedge clk);
        while (tick_queue.size() != 0 || in_valid || camera_expect.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic add_tick(logic [15:0] dt, logic [15:0] hd, logic [31:0] x, logic [31:0] y);
        tick_t tk;
        tk.dt = dt;
        tk.heading = hd;
        tk.px = x;
        tk.py = y;
        tick_queue.push_back(tk);
    endtask

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($urandom_range(0, 2 ** 21) - 2 ** 20);
    endfunction

    task automatic add_random_ticks(int n);
        logic [15:0] dt;
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0: dt = 16'($urandom);
                1: dt = 16'($urandom_range(0, 16));
                default: dt = 16'($urandom_range(0, 4000));
            endcase
            add_tick(dt, 16'($urandom), rand_pos(), rand_pos());
        end
    endtask

    function automatic logic [23:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 2 ** 17) - 2 ** 16);
        endcase
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return 24'd0;
            1: return 24'd65535;
            2: return 24'($urandom_range(0, 65535));
            default: return 24'($urandom_range(256, 4096));
        endcase
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under the reset register values.
        add_tick(16'd0, 16'd1000, 32'd5000, 32'd5000);
        add_tick(16'd65535, 16'd32768, 32'h7FFFFFFF, 32'h80000000);
        add_tick(16'd1092, 16'd65535, 32'h80000000, 32'h7FFFFFFF);
        add_tick(16'd1092, 16'd0, 32'hFFFFFFFF, 32'd0);
        add_tick(16'd1092, 16'd16384, 32'd0, 32'hFFFFFFFF);
        add_tick(16'd1092, 16'd49152, 32'h55555555, 32'hAAAAAAAA);
        add_tick(16'd65535, 16'd12345, 32'hAAAAAAAA, 32'h55555555);
        drain();

        // Exact half turn from a known angle, then maximum gains so both wrap.
        write_reg(CFG_ROTATION_GAIN, 24'd256);
        write_reg(CFG_POSITION_GAIN, 24'd65535);
        write_reg(CFG_OFFSET_X, 24'h7FFFFF);
        write_reg(CFG_OFFSET_Y, 24'h800000);
        write_reg(CFG_ROTATION_GAIN + 8'd1, 24'hFFFFFF);
        write_reg(8'hFF, 24'h123456);
        end_writes();
        add_tick(16'd0, 16'd32768, 32'd0, 32'd0);
        add_tick(16'd65535, 16'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        drain();
        write_reg(CFG_ROTATION_GAIN, 24'd65535);
        end_writes();
        add_tick(16'd65535, 16'd32767, 32'h80000000, 32'h7FFFFFFF);
        add_tick(16'd65535, 16'd100, 32'h7FFFFFFF, 32'h80000000);
        add_tick(16'd40000, 16'd60000, 32'h12345678, 32'h87654321);
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_OFFSET_X, pick_offset());
            write_reg(CFG_OFFSET_Y, pick_offset());
            write_reg(CFG_POSITION_GAIN, pick_gain());
            write_reg(CFG_ROTATION_GAIN, pick_gain());
            end_writes();
            add_random_ticks(153);
            drain();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
